### hdl/ctsl_pkg.sv
// Shared types, codes and lookup functions for the C-style token lexer.
`timescale 1ns / 1ps
package ctsl_pkg;

  localparam int MAX_TEXT_CHARS = 8;
  localparam int FIFO_DEPTH     = 4;

  localparam logic [2:0] MODE_IDLE  = 3'd0;
  localparam logic [2:0] MODE_OPER  = 3'd1;
  localparam logic [2:0] MODE_NUM   = 3'd2;
  localparam logic [2:0] MODE_IDENT = 3'd3;
  localparam logic [2:0] MODE_LINE  = 3'd4;
  localparam logic [2:0] MODE_BLOCK = 3'd5;
  localparam logic [2:0] MODE_STAR  = 3'd6;

  localparam logic [5:0] KIND_TERM   = 6'd0;
  localparam logic [5:0] KIND_IDENT  = 6'd1;
  localparam logic [5:0] KIND_INT    = 6'd2;
  localparam logic [5:0] KIND_LPAREN = 6'd4;
  localparam logic [5:0] KIND_RPAREN = 6'd5;
  localparam logic [5:0] KIND_SHL    = 6'd11;
  localparam logic [5:0] KIND_SHR    = 6'd12;
  localparam logic [5:0] KIND_SHL_EQ = 6'd30;
  localparam logic [5:0] KIND_SHR_EQ = 6'd31;
  localparam logic [5:0] KIND_COMMA  = 6'd35;
  localparam logic [5:0] KIND_KW0    = 6'd36;
  localparam logic [5:0] KIND_ERROR  = 6'd45;
  localparam logic [5:0] KIND_EOF    = 6'd46;

  typedef struct packed {
    logic [5:0]  kind;
    logic [31:0] value;
    logic [63:0] text;
    logic [7:0]  length;
    logic        last;
  } token_t;

  typedef struct packed {
    logic       ok;
    logic [5:0] kind;
  } kind_t;

  // Kind of a one-character operator; '!' maps to Error.
  function automatic kind_t single_kind(input logic [7:0] c);
    kind_t r;
    r.ok = 1'b1;
    unique case (c)
      8'h3B: r.kind = 6'd0;   8'h28: r.kind = 6'd4;   8'h29: r.kind = 6'd5;
      8'h2A: r.kind = 6'd6;   8'h2F: r.kind = 6'd7;   8'h25: r.kind = 6'd8;
      8'h2B: r.kind = 6'd9;   8'h2D: r.kind = 6'd10;  8'h3C: r.kind = 6'd13;
      8'h3E: r.kind = 6'd15;  8'h26: r.kind = 6'd19;  8'h5E: r.kind = 6'd20;
      8'h7C: r.kind = 6'd21;  8'h3D: r.kind = 6'd24;  8'h2C: r.kind = 6'd35;
      8'h21: r.kind = KIND_ERROR;
      default: begin
        r.ok   = 1'b0;
        r.kind = KIND_ERROR;
      end
    endcase
    return r;
  endfunction

  function automatic kind_t pair_kind(input logic [7:0] a, input logic [7:0] b);
    kind_t r;
    r.ok   = 1'b1;
    r.kind = KIND_ERROR;
    priority if (a == 8'h3C && b == 8'h3C) r.kind = 6'd11;
    else if (a == 8'h3E && b == 8'h3E) r.kind = 6'd12;
    else if (a == 8'h26 && b == 8'h26) r.kind = 6'd22;
    else if (a == 8'h7C && b == 8'h7C) r.kind = 6'd23;
    else if (b != 8'h3D) r.ok = 1'b0;
    else begin
      unique case (a)
        8'h3C: r.kind = 6'd14;  8'h3E: r.kind = 6'd16;  8'h3D: r.kind = 6'd17;
        8'h21: r.kind = 6'd18;  8'h2B: r.kind = 6'd25;  8'h2D: r.kind = 6'd26;
        8'h2A: r.kind = 6'd27;  8'h2F: r.kind = 6'd28;  8'h25: r.kind = 6'd29;
        8'h26: r.kind = 6'd32;  8'h5E: r.kind = 6'd33;  8'h7C: r.kind = 6'd34;
        default: r.ok = 1'b0;
      endcase
    end
    return r;
  endfunction

  // Packed keyword text and length, indexed in token order.
  function automatic logic [63:0] kw_text(input logic [3:0] k);
    logic [63:0] t;
    unique case (k)
      4'd0: t = 64'h6669;                 // if
      4'd1: t = 64'h6573_6C65;            // else
      4'd2: t = 64'h65_6C69_6877;         // while
      4'd3: t = 64'h73_7361_6C63;         // class
      4'd4: t = 64'h74_6E69;              // int
      4'd5: t = 64'h74_616F_6C66;         // float
      4'd6: t = 64'h6469_6F76;            // void
      4'd7: t = 64'h72_6F66;              // for
      4'd8: t = 64'h6E72_7574_6572;       // return
      default: t = 64'h0;
    endcase
    return t;
  endfunction

  function automatic logic [7:0] kw_len(input logic [3:0] k);
    logic [7:0] n;
    unique case (k)
      4'd0: n = 8'd2;  4'd1: n = 8'd4;  4'd2: n = 8'd5;  4'd3: n = 8'd5;
      4'd4: n = 8'd3;  4'd5: n = 8'd5;  4'd6: n = 8'd4;  4'd7: n = 8'd3;
      4'd8: n = 8'd6;
      default: n = 8'd0;
    endcase
    return n;
  endfunction

endpackage

### hdl/ctsl_scan.sv
// Next-state and token logic of the lexer for one input byte.
`timescale 1ns / 1ps
module ctsl_scan (
  input  logic [2:0]        mode,
  input  logic [15:0]       pend,
  input  logic [31:0]       acc,
  input  logic [63:0]       buf_text,
  input  logic [7:0]        cnt,
  input  logic [7:0]        c,
  input  logic              eoi,
  output logic [2:0]        mode_nxt,
  output logic [15:0]       pend_nxt,
  output logic [31:0]       acc_nxt,
  output logic [63:0]       buf_nxt,
  output logic [7:0]        cnt_nxt,
  output ctsl_pkg::token_t  tok0,
  output ctsl_pkg::token_t  tok1,
  output logic [1:0]        n_tok
);

  logic [7:0] c1, c2;
  logic is_digit, is_alpha, is_space;
  ctsl_pkg::kind_t sk_c, sk_c1, pk, pk_pend;
  ctsl_pkg::token_t ftok, itok, dtok, eof_tok;
  logic fvalid, ivalid, dvalid, fall;
  logic [5:0] id_kind;
  logic [2:0] imode;
  logic [15:0] ipend;
  logic [31:0] iacc;
  logic [63:0] ibuf, appended;
  logic [7:0] icnt;

  assign c1 = pend[7:0];
  assign c2 = pend[15:8];
  assign is_digit = (c >= 8'h30) && (c <= 8'h39);
  assign is_alpha = ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A))
                    || (c == 8'h5F);
  assign is_space = (c == 8'h20) || (c == 8'h09) || (c == 8'h0A) || (c == 8'h0D);
  assign sk_c    = ctsl_pkg::single_kind(c);
  assign sk_c1   = ctsl_pkg::single_kind(c1);
  assign pk      = ctsl_pkg::pair_kind(c1, c);
  assign pk_pend = ctsl_pkg::pair_kind(c1, c2);

  always_comb begin
    id_kind = ctsl_pkg::KIND_IDENT;
    for (int k = 8; k >= 0; k--) begin
      if (cnt == ctsl_pkg::kw_len(4'(k)) && buf_text == ctsl_pkg::kw_text(4'(k)))
        id_kind = ctsl_pkg::KIND_KW0 + 6'(k);
    end
  end

  // Pending token flush.
  always_comb begin
    ftok   = '0;
    fvalid = 1'b1;
    unique case (mode)
      ctsl_pkg::MODE_OPER:  ftok.kind = (c2 != 8'h0) ? pk_pend.kind : sk_c1.kind;
      ctsl_pkg::MODE_NUM: begin
        ftok.kind  = ctsl_pkg::KIND_INT;
        ftok.value = acc;
      end
      ctsl_pkg::MODE_IDENT: begin
        ftok.kind   = id_kind;
        ftok.text   = buf_text;
        ftok.length = cnt;
      end
      default: fvalid = 1'b0;
    endcase
  end

  // Scan of the byte from a cleared state.
  always_comb begin
    itok   = '0;
    ivalid = 1'b0;
    imode  = ctsl_pkg::MODE_IDLE;
    ipend  = '0;
    iacc   = '0;
    ibuf   = '0;
    icnt   = '0;
    priority if (is_space) begin
    end else if (is_digit) begin
      imode = ctsl_pkg::MODE_NUM;
      iacc  = 32'(c - 8'h30);
    end else if (is_alpha) begin
      imode = ctsl_pkg::MODE_IDENT;
      ibuf  = 64'(c);
      icnt  = 8'd1;
    end else if (!sk_c.ok) begin
      ivalid    = 1'b1;
      itok.kind = ctsl_pkg::KIND_ERROR;
    end else if (sk_c.kind == ctsl_pkg::KIND_TERM || sk_c.kind == ctsl_pkg::KIND_LPAREN ||
                 sk_c.kind == ctsl_pkg::KIND_RPAREN || sk_c.kind == ctsl_pkg::KIND_COMMA) begin
      ivalid    = 1'b1;
      itok.kind = sk_c.kind;
    end else begin
      imode = ctsl_pkg::MODE_OPER;
      ipend = {8'h0, c};
    end
  end

  always_comb begin
    appended = buf_text;
    for (int i = 0; i < ctsl_pkg::MAX_TEXT_CHARS; i++) begin
      if (cnt == 8'(i)) appended[8*i +: 8] = c;
    end
  end

  // Main decision: either a direct result, or flush then idle scan.
  always_comb begin
    mode_nxt = mode;
    pend_nxt = pend;
    acc_nxt  = acc;
    buf_nxt  = buf_text;
    cnt_nxt  = cnt;
    dtok     = '0;
    dvalid   = 1'b0;
    fall     = 1'b0;
    eof_tok  = '0;
    eof_tok.kind = ctsl_pkg::KIND_EOF;
    if (!eoi) begin
      unique case (mode)
        ctsl_pkg::MODE_OPER: begin
          if (c2 != 8'h0) begin
            if (c == 8'h3D) begin
              dvalid    = 1'b1;
              dtok.kind = (c1 == 8'h3C) ? ctsl_pkg::KIND_SHL_EQ : ctsl_pkg::KIND_SHR_EQ;
            end else fall = 1'b1;
          end else if (c1 == 8'h2F && c == 8'h2F) begin
            dvalid = 1'b0;
          end else if (c1 == 8'h2F && c == 8'h2A) begin
            dvalid = 1'b0;
          end else if (pk.ok && (pk.kind == ctsl_pkg::KIND_SHL ||
                                 pk.kind == ctsl_pkg::KIND_SHR)) begin
            pend_nxt = {c, c1};
          end else if (pk.ok) begin
            dvalid    = 1'b1;
            dtok.kind = pk.kind;
          end else fall = 1'b1;
          if (!fall && !(pk.ok && c2 == 8'h0 && (pk.kind == ctsl_pkg::KIND_SHL ||
                                                  pk.kind == ctsl_pkg::KIND_SHR))) begin
            pend_nxt = '0;
            mode_nxt = ctsl_pkg::MODE_IDLE;
            if (c2 == 8'h0 && c1 == 8'h2F && c == 8'h2F) mode_nxt = ctsl_pkg::MODE_LINE;
            if (c2 == 8'h0 && c1 == 8'h2F && c == 8'h2A) mode_nxt = ctsl_pkg::MODE_BLOCK;
          end
        end
        ctsl_pkg::MODE_NUM: begin
          if (is_digit) acc_nxt = {acc[28:0], 3'b0} + {acc[30:0], 1'b0} + 32'(c - 8'h30);
          else fall = 1'b1;
        end
        ctsl_pkg::MODE_IDENT: begin
          if (is_digit || is_alpha) begin
            if (cnt < 8'(ctsl_pkg::MAX_TEXT_CHARS)) buf_nxt = appended;
            if (cnt != 8'hFF) cnt_nxt = cnt + 8'd1;
          end else fall = 1'b1;
        end
        ctsl_pkg::MODE_LINE: if (c == 8'h0A) mode_nxt = ctsl_pkg::MODE_IDLE;
        ctsl_pkg::MODE_BLOCK: if (c == 8'h2A) mode_nxt = ctsl_pkg::MODE_STAR;
        ctsl_pkg::MODE_STAR: begin
          if (c == 8'h2F) mode_nxt = ctsl_pkg::MODE_IDLE;
          else if (c != 8'h2A) mode_nxt = ctsl_pkg::MODE_BLOCK;
        end
        default: fall = 1'b1;
      endcase
      if (fall) begin
        mode_nxt = imode;
        pend_nxt = ipend;
        acc_nxt  = iacc;
        buf_nxt  = ibuf;
        cnt_nxt  = icnt;
      end
    end else begin
      mode_nxt = ctsl_pkg::MODE_IDLE;
      pend_nxt = '0;
      acc_nxt  = '0;
      buf_nxt  = '0;
      cnt_nxt  = '0;
    end
  end

  // Pack results in order; mark the final one.
  always_comb begin
    tok0  = '0;
    tok1  = '0;
    n_tok = 2'd0;
    if (eoi) begin
      if (fvalid) begin
        tok0 = ftok;
        tok1 = eof_tok;
        n_tok = 2'd2;
      end else begin
        tok0 = eof_tok;
        n_tok = 2'd1;
      end
    end else if (fall) begin
      if (fvalid && ivalid) begin
        tok0 = ftok;
        tok1 = itok;
        n_tok = 2'd2;
      end else if (fvalid) begin
        tok0 = ftok;
        n_tok = 2'd1;
      end else if (ivalid) begin
        tok0 = itok;
        n_tok = 2'd1;
      end
    end else if (dvalid) begin
      tok0 = dtok;
      n_tok = 2'd1;
    end
    if (n_tok == 2'd2) tok1.last = 1'b1;
    else if (n_tok == 2'd1) tok0.last = 1'b1;
  end

endmodule

### hdl/ctsl_fifo.sv
// Result queue: takes up to two tokens a cycle, hands out one.
`timescale 1ns / 1ps
module ctsl_fifo (
  input  logic             clk,
  input  logic             rst_n,
  input  logic [1:0]       push_n,
  input  ctsl_pkg::token_t push0,
  input  ctsl_pkg::token_t push1,
  input  logic             pop,
  output ctsl_pkg::token_t head,
  output logic             not_empty,
  output logic             room2,
  output logic [2:0]       level
);

  ctsl_pkg::token_t mem [ctsl_pkg::FIFO_DEPTH];
  logic [1:0] wr_r, rd_r, wr_nxt, rd_nxt;
  logic [2:0] cnt_r, cnt_nxt;

  assign head      = mem[rd_r];
  assign not_empty = cnt_r != 3'd0;
  assign room2     = cnt_r <= 3'd2;
  assign level     = cnt_r;

  always_comb begin
    wr_nxt  = wr_r + push_n;
    rd_nxt  = rd_r + 2'(pop);
    cnt_nxt = cnt_r + 3'(push_n) - 3'(pop);
  end

  always_ff @(posedge clk) begin
    if (push_n != 2'd0) mem[wr_r] <= push0;
    if (push_n == 2'd2) mem[wr_r + 2'd1] <= push1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

### hdl/c_style_token_lexer.sv
// Top level of the streaming C-style token lexer.
`timescale 1ns / 1ps
// Streaming lexer: one source byte (or an end-of-input mark) per transfer on
// the in_ channel, tokens out on the out_ channel. A byte is taken every
// cycle while the four-entry result queue has room for two tokens; each byte
// yields zero, one or two tokens, the last one flagged by out_last_of_run.
// The scan state and the token decision are settled in the cycle of the
// transfer, and the tokens are registered into the result queue; the
// sustained rate is one byte per cycle, bounded only by the one-token-a-cycle
// drain of the result queue. Identifier text holds the first eight bytes,
// length saturates at 255. After end of input the lexer starts afresh.
module c_style_token_lexer (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_char_code,
  input  logic        in_end_of_input,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [5:0]  out_token_kind,
  output logic [31:0] out_int_value,
  output logic [63:0] out_text_chars,
  output logic [7:0]  out_text_length,
  output logic        out_last_of_run
);

  logic [2:0]  mode_r, mode_nxt;
  logic [15:0] pend_r, pend_nxt;
  logic [31:0] acc_r, acc_nxt;
  logic [63:0] buf_r, buf_nxt;
  logic [7:0]  cnt_r, cnt_nxt;
  ctsl_pkg::token_t tok0, tok1, head;
  logic [1:0] n_tok;
  logic in_xfer, room2, not_empty;
  logic [2:0] level;

  assign in_xfer  = in_valid && in_ready;
  assign in_ready = room2;

  ctsl_scan u_scan (
    .mode(mode_r), .pend(pend_r), .acc(acc_r), .buf_text(buf_r), .cnt(cnt_r),
    .c(in_char_code), .eoi(in_end_of_input),
    .mode_nxt(mode_nxt), .pend_nxt(pend_nxt), .acc_nxt(acc_nxt),
    .buf_nxt(buf_nxt), .cnt_nxt(cnt_nxt),
    .tok0(tok0), .tok1(tok1), .n_tok(n_tok)
  );

  // Push only on an input transfer; pop on an output transfer.
  ctsl_fifo u_fifo (
    .clk(clk), .rst_n(rst_n),
    .push_n(in_xfer ? n_tok : 2'd0), .push0(tok0), .push1(tok1),
    .pop(out_valid && out_ready),
    .head(head), .not_empty(not_empty), .room2(room2), .level(level)
  );

  assign out_valid       = not_empty;
  assign out_token_kind  = head.kind;
  assign out_int_value   = head.value;
  assign out_text_chars  = head.text;
  assign out_text_length = head.length;
  assign out_last_of_run = head.last;

  // Advance scan state on each input transfer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= ctsl_pkg::MODE_IDLE;
      pend_r <= '0;
      acc_r  <= '0;
      buf_r  <= '0;
      cnt_r  <= '0;
    end else if (in_xfer) begin
      mode_r <= mode_nxt;
      pend_r <= pend_nxt;
      acc_r  <= acc_nxt;
      buf_r  <= buf_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // Queue never overfills.
  a_level: assert property (@(posedge clk) disable iff (!rst_n)
    level <= 3'(ctsl_pkg::FIFO_DEPTH))
    else $error("result queue overflow");

  // End of input returns the scanner to idle.
  a_eof_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (in_xfer && in_end_of_input) |=> (mode_r == ctsl_pkg::MODE_IDLE && cnt_r == 8'd0))
    else $error("scanner not idle after end of input");

  // Identifier count is zero outside identifier mode.
  a_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    (mode_r != ctsl_pkg::MODE_IDENT) |-> (cnt_r == 8'd0))
    else $error("stale identifier count");

endmodule
